// ----- rtl/gnss_binary_frame_sync_checker_assert.svh -----
// Assertion macros for the frame sync checker.
// Each check is clocked on clk_i and held off while rst_ni is low.
`ifndef GNSS_BINARY_FRAME_SYNC_CHECKER_ASSERT_SVH
`define GNSS_BINARY_FRAME_SYNC_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define GBFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GBFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GBFS_ASSERT_IMP(lbl, ante, cons, msg)
`define GBFS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/gbfs_pkg.sv -----
package gbfs_pkg;

  // Queue between the classifier and the checksum stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned PosW = 9;

  // Framing constants
  localparam logic [7:0]      StartByte = 8'h01;
  localparam logic [8:0]      IdSum     = 9'd255;
  localparam logic [PosW-1:0] LenOffset = 9'd6;
  // Start byte plus id plus complement always sums to 0x100
  localparam logic [15:0]     SyncSum   = 16'h0100;

  // Length rules per message id
  localparam logic [7:0]      IdA   = 8'd20;
  localparam logic [7:0]      IdB   = 8'd21;
  localparam logic [7:0]      IdC   = 8'd22;
  localparam logic [7:0]      IdObs = 8'd23;
  localparam logic [PosW-1:0] LenA  = 9'd77;
  localparam logic [PosW-1:0] LenB  = 9'd85;
  localparam logic [PosW-1:0] LenC  = 9'd79;
  localparam logic [11:0]     ObsBase = 12'd17;
  localparam logic [11:0]     ObsStep = 12'd11;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_GOOD     = 2'd1,
    VERDICT_CSUM_ERR = 2'd2,
    VERDICT_LEN_ERR  = 2'd3
  } verdict_e;

  // One classified byte on its way to the checksum stage
  typedef struct packed {
    logic [7:0]      data;
    logic [PosW-1:0] pos;
    logic            in_frame;
    logic            done;
    logic            sync;
    logic            sum_en;
    logic            low_cap;
    logic            len_ok;
    logic [7:0]      msg_id;
  } gbfs_item_t;

endpackage

// ----- rtl/gbfs_front.sv -----
module gbfs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output gbfs_pkg::gbfs_item_t item_o
);
  import gbfs_pkg::*;

  // Middle and newest bytes of the header window; the oldest byte is only
  // ever needed after a shift, when it is the old middle byte
  logic [7:0]      hw_mid_q, hw_mid_d;
  logic [7:0]      hw_new_q, hw_new_d;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] len_q, len_d;
  logic [7:0]      obs_q, obs_d;

  logic            accept;
  logic            hunting;
  logic            sync;
  logic [PosW-1:0] len_eff;
  logic [7:0]      obs_eff;
  logic [PosW-1:0] cnt_inc;
  logic [PosW:0]   pos_p2;
  logic [11:0]     obs_need;
  logic            len_ok;
  logic            done;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;

  // Classify the incoming byte
  always_comb begin
    hunting  = (cnt_q == '0);
    sync     = hunting && (hw_mid_q == StartByte) &&
               (({1'b0, hw_new_q} + {1'b0, rx_byte_i}) == IdSum);
    len_eff  = (cnt_q == PosW'(3)) ? ({1'b0, rx_byte_i} + LenOffset) : len_q;
    obs_eff  = (cnt_q == PosW'(6)) ? rx_byte_i : obs_q;
    cnt_inc  = cnt_q + PosW'(1);
    pos_p2   = {1'b0, cnt_q} + (PosW+1)'(2);
    obs_need = ObsBase + 12'(obs_eff) * ObsStep;
    done     = !hunting && (cnt_inc == len_eff);

    case (hw_mid_q)
      IdA:     len_ok = (len_eff == LenA);
      IdB:     len_ok = (len_eff == LenB);
      IdC:     len_ok = (len_eff == LenC);
      IdObs:   len_ok = (obs_need == 12'(len_eff));
      default: len_ok = 1'b1;
    endcase

    item_o.data     = rx_byte_i;
    item_o.pos      = hunting ? (sync ? PosW'(2) : '0) : cnt_q;
    item_o.in_frame = hunting ? sync : 1'b1;
    item_o.done     = done;
    item_o.sync     = sync;
    item_o.sum_en   = !hunting && (pos_p2 < {1'b0, len_eff});
    item_o.low_cap  = !hunting && (pos_p2 == {1'b0, len_eff});
    item_o.len_ok   = len_ok;
    item_o.msg_id   = hunting ? hw_new_q : hw_mid_q;
  end

  // Advance the window or the frame counter
  always_comb begin
    hw_mid_d = hw_mid_q;
    hw_new_d = hw_new_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    obs_d    = obs_q;
    if (accept) begin
      if (hunting) begin
        hw_mid_d = hw_new_q;
        hw_new_d = rx_byte_i;
        cnt_d    = sync ? PosW'(3) : '0;
      end else begin
        cnt_d = done ? '0 : cnt_inc;
        if (cnt_q == PosW'(3)) len_d = len_eff;
        if (cnt_q == PosW'(6)) obs_d = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_mid_q <= '0;
      hw_new_q <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
      obs_q    <= '0;
    end else begin
      hw_mid_q <= hw_mid_d;
      hw_new_q <= hw_new_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      obs_q    <= obs_d;
    end
  end

endmodule

// ----- rtl/gbfs_queue.sv -----
module gbfs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gbfs_pkg::gbfs_item_t item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output gbfs_pkg::gbfs_item_t item_o
);
  import gbfs_pkg::*;

  gbfs_item_t       slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCntW'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold item storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

endmodule

// ----- rtl/gbfs_back.sv -----
module gbfs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  gbfs_pkg::gbfs_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           echo_byte_o,
  output logic [8:0]           byte_position_o,
  output logic                 inside_frame_o,
  output logic                 frame_done_o,
  output logic [1:0]           verdict_o,
  output logic [7:0]           message_id_o
);
  import gbfs_pkg::*;

  logic [15:0]     sum_q, sum_d;
  logic [7:0]      low_q, low_d;
  logic            vld_q, vld_d;
  logic [7:0]      echo_q;
  logic [PosW-1:0] pos_q;
  logic            inside_q;
  logic            done_q;
  verdict_e        verdict_q, verdict_d;
  logic [7:0]      id_q;

  assign pop_o = q_valid_i && (!vld_q || !out_stall_i);

  // Accumulate the checksum and judge the frame on its last byte
  always_comb begin
    sum_d = sum_q;
    low_d = low_q;
    vld_d = vld_q && out_stall_i;
    verdict_d = VERDICT_NONE;
    if (item_i.done) begin
      if ((sum_q[15:8] != item_i.data) || (sum_q[7:0] != low_q)) begin
        verdict_d = VERDICT_CSUM_ERR;
      end else if (item_i.len_ok) begin
        verdict_d = VERDICT_GOOD;
      end else begin
        verdict_d = VERDICT_LEN_ERR;
      end
    end
    if (pop_o) begin
      vld_d = 1'b1;
      if (item_i.sync) begin
        sum_d = SyncSum;
      end else if (item_i.sum_en) begin
        sum_d = sum_q + 16'(item_i.data);
      end
      if (item_i.low_cap) low_d = item_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      low_q <= '0;
      vld_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      low_q <= low_d;
      vld_q <= vld_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      echo_q    <= item_i.data;
      pos_q     <= item_i.pos;
      inside_q  <= item_i.in_frame;
      done_q    <= item_i.done;
      verdict_q <= verdict_d;
      id_q      <= item_i.msg_id;
    end
  end

  assign out_valid_o     = vld_q;
  assign echo_byte_o     = echo_q;
  assign byte_position_o = pos_q;
  assign inside_frame_o  = inside_q;
  assign frame_done_o    = done_q;
  assign verdict_o       = verdict_q;
  assign message_id_o    = id_q;

endmodule

// ----- rtl/gnss_binary_frame_sync_checker.sv -----
// An accepted byte is written into a queue slot and then into the output register.
// Throughput: one byte per cycle; a 4-entry queue separates the classifier
// from the checksum stage, so input stalls only when that queue fills.
// Reset (rst_ni low, asynchronous): header window, frame counter, length,
// checksum and queue clear to zero; no result is valid after reset.
`include "gnss_binary_frame_sync_checker_assert.svh"

module gnss_binary_frame_sync_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] echo_byte_o,
  output logic [8:0] byte_position_o,
  output logic       inside_frame_o,
  output logic       frame_done_o,
  output logic [1:0] verdict_o,
  output logic [7:0] message_id_o
);
  import gbfs_pkg::*;

  gbfs_item_t push_item;
  gbfs_item_t head_item;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;

  // Classify bytes and track framing
  gbfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .item_o     (push_item)
  );

  // Decouple the two halves
  gbfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // Sum, check and present results
  gbfs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .item_i          (head_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .echo_byte_o     (echo_byte_o),
    .byte_position_o (byte_position_o),
    .inside_frame_o  (inside_frame_o),
    .frame_done_o    (frame_done_o),
    .verdict_o       (verdict_o),
    .message_id_o    (message_id_o)
  );

  `GBFS_ASSERT_IMP(a_done_inside, out_valid_o && frame_done_o, inside_frame_o,
                   "frame end outside a frame")
  `GBFS_ASSERT_IMP(a_verdict_on_done, out_valid_o,
                   frame_done_o == (verdict_o != VERDICT_NONE), "verdict without frame end")
  `GBFS_ASSERT_IMP(a_min_frame, push && push_item.done, push_item.pos >= PosW'(5),
                   "frame shorter than six bytes")
  `GBFS_ASSERT_NXT(a_pop_shows, pop, out_valid_o, "popped item not presented")

endmodule
